>>> hw/rtl/crm_pkg.sv
// shared types, constants and helpers of the crystal region mapper
`default_nettype none

package crm_pkg;

    // sizes
    localparam int MAX_REGIONS_DEF = 1024;
    localparam int QUEUE_DEPTH     = 4;
    localparam int PADDR_W         = 5;
    localparam int DIV_W           = 10;   // dividend and quotient width
    localparam int DIVR_W          = 9;    // divisor width
    localparam int DIV_STEPS       = 2;    // quotient bits per cycle
    localparam int ID_W            = 21;   // raw region id before capacity check

    // crystal numbering
    localparam int HASH_BASE   = 30600;
    localparam int PHI_ROW     = 360;
    localparam int ETA_NEG_OFS = 85;
    localparam int ETA_POS_OFS = 84;
    localparam int ETA_MAX     = 85;

    // register indexes
    localparam logic [2:0] REG_ETA_FIRST = 3'd0;
    localparam logic [2:0] REG_ETA_LAST  = 3'd1;
    localparam logic [2:0] REG_ETA_STEP  = 3'd2;
    localparam logic [2:0] REG_PHI_FIRST = 3'd3;
    localparam logic [2:0] REG_PHI_LAST  = 3'd4;
    localparam logic [2:0] REG_PHI_STEP  = 3'd5;

    // register reset values
    localparam logic [7:0] ETA_FIRST_RST = 8'hAB;
    localparam logic [7:0] ETA_LAST_RST  = 8'd86;
    localparam logic [7:0] ETA_STEP_RST  = 8'd5;
    localparam logic [8:0] PHI_FIRST_RST = 9'd1;
    localparam logic [8:0] PHI_LAST_RST  = 9'd361;
    localparam logic [8:0] PHI_STEP_RST  = 9'd20;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ETA_LOW  = 3'd1,
        ST_ETA_HIGH = 3'd2,
        ST_PHI_LOW  = 3'd3,
        ST_PHI_HIGH = 3'd4,
        ST_ETA_ZERO = 3'd5,
        ST_OVER_CAP = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_WAIT_CNT,
        BK_WAIT_SLOT,
        BK_MUL,
        BK_ADDR,
        BK_WRITE
    } back_state_t;

    typedef struct packed {
        logic [7:0] eta_first;
        logic [7:0] eta_last;
        logic [7:0] eta_step;
        logic [8:0] phi_first;
        logic [8:0] phi_last;
        logic [8:0] phi_step;
    } crm_cfg_t;

    // classified request as it travels from front to back
    typedef struct packed {
        status_t    status;
        logic [15:0] hash;
        logic [7:0] eta_off;
        logic [8:0] phi_off;
    } crm_item_t;

    // eta with zero skipped: negative side from 0, positive side from 85
    function automatic logic signed [8:0] shift_eta(input logic [7:0] e);
        logic signed [8:0] ex;
        ex = 9'($signed(e));
        if (ex < 0)
            return ex + 9'(ETA_NEG_OFS);
        else if (ex > 0)
            return ex + 9'(ETA_POS_OFS);
        else
            return '0;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/crm_front.sv
// front: window check, crystal hash and slot offsets of each request
`default_nettype none

module crm_front (
    input  wire logic              push,
    input  wire logic              stall,
    input  wire logic signed [7:0] eta_index,
    input  wire logic [8:0]        phi_index,
    input  wire crm_pkg::crm_cfg_t cfg,
    output logic                   wr_en,
    output crm_pkg::crm_item_t     item
);

    logic signed [8:0]  e_loc;
    logic signed [8:0]  e_start;
    logic signed [8:0]  e_end;
    logic signed [9:0]  e_diff;
    logic [8:0]         phi_diff;
    logic               hash_ok;
    logic signed [7:0]  row;
    logic signed [17:0] hash_sum;
    crm_pkg::status_t   status;

    assign wr_en = push && !stall;

    assign e_loc   = crm_pkg::shift_eta(eta_index);
    assign e_start = crm_pkg::shift_eta(cfg.eta_first);
    assign e_end   = crm_pkg::shift_eta(cfg.eta_last);

    // first failing test wins
    always_comb
    begin
        if (e_loc < e_start)
            status = crm_pkg::ST_ETA_LOW;
        else if (e_loc >= e_end)
            status = crm_pkg::ST_ETA_HIGH;
        else if (phi_index < cfg.phi_first)
            status = crm_pkg::ST_PHI_LOW;
        else if (phi_index >= cfg.phi_last)
            status = crm_pkg::ST_PHI_HIGH;
        else if (eta_index == 8'sd0)
            status = crm_pkg::ST_ETA_ZERO;
        else
            status = crm_pkg::ST_OK;
    end

    assign e_diff   = 10'(e_loc) - 10'(e_start);
    assign phi_diff = phi_index - cfg.phi_first;

    assign hash_ok = (eta_index != 8'sd0)
                  && (eta_index >= -8'(crm_pkg::ETA_MAX))
                  && (eta_index <= 8'(crm_pkg::ETA_MAX))
                  && (phi_index >= 9'd1)
                  && (phi_index <= 9'(crm_pkg::PHI_ROW));

    // positive side drops one row to close the gap left by zero
    assign row      = (eta_index < 0) ? eta_index : eta_index - 8'sd1;
    assign hash_sum = 18'(row) * 18'sd360 + 18'sd30599 + $signed({9'b0, phi_index});

    always_comb
    begin
        item.status  = status;
        item.hash    = hash_ok ? hash_sum[15:0] : 16'd0;
        item.eta_off = e_diff[7:0];
        item.phi_off = phi_diff;
    end

endmodule

`default_nettype wire

>>> hw/rtl/crm_fifo.sv
// short request queue between front and back
`default_nettype none

module crm_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire crm_pkg::crm_item_t wr_data,
    input  wire logic               rd_en,
    output crm_pkg::crm_item_t      rd_data,
    output logic                    fifo_full,
    output logic                    fifo_empty
);

    localparam int PTR_W = $clog2(crm_pkg::QUEUE_DEPTH);

    crm_pkg::crm_item_t entry_reg [crm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic [PTR_W:0]     count_next;

    assign fifo_full  = (count_reg == (PTR_W+1)'(crm_pkg::QUEUE_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign rd_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

>>> hw/rtl/crm_div.sv
// restoring divider, a few quotient bits per cycle
`default_nettype none

module crm_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [crm_pkg::DIV_W-1:0]   dividend,
    input  wire logic [crm_pkg::DIVR_W-1:0]  divisor,
    output logic                             busy,
    output logic [crm_pkg::DIV_W-1:0]        quotient
);

    localparam int W      = crm_pkg::DIV_W;
    localparam int CYCLES = crm_pkg::DIV_W / crm_pkg::DIV_STEPS;
    localparam int CNT_W  = (CYCLES > 1) ? $clog2(CYCLES) : 1;

    logic                       busy_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [W-1:0]               rem_reg;
    logic [W-1:0]               quo_reg;
    logic [crm_pkg::DIVR_W-1:0] dvs_reg;
    logic [W-1:0]               rem_next;
    logic [W-1:0]               quo_next;
    logic [W-1:0]               shifted;

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    // remainder stays below the divisor, so its top bit is always clear
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        shifted  = '0;
        for (int i = 0; i < crm_pkg::DIV_STEPS; i++)
        begin
            shifted  = {rem_next[W-2:0], quo_next[W-1]};
            quo_next = {quo_next[W-2:0], 1'b0};
            if (shifted >= W'(dvs_reg))
            begin
                shifted     = shifted - W'(dvs_reg);
                quo_next[0] = 1'b1;
            end
            rem_next = shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(CYCLES - 1))
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/crm_back.sv
// back: region counts, region id, fill counter update and result register
`default_nettype none

module crm_back #(
    parameter int MAX_REGIONS = crm_pkg::MAX_REGIONS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire crm_pkg::crm_cfg_t  cfg,
    input  wire crm_pkg::crm_item_t item,
    input  wire logic               item_empty,
    output logic                    item_pop,
    output logic                    clearing,
    input  wire logic               pop,
    output logic                    empty,
    output logic [2:0]              status,
    output logic [9:0]              region_id,
    output logic [15:0]             crystal_hash,
    output logic [15:0]             position_in_region,
    output logic [15:0]             region_total
);

    localparam int ADDR_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int W      = crm_pkg::DIV_W;
    localparam int ID_W   = crm_pkg::ID_W;

    crm_pkg::back_state_t state_reg;
    crm_pkg::back_state_t state_next;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              out_load;

    crm_pkg::crm_item_t item_reg;
    logic [W-1:0]       n_eta_reg;
    logic [W-1:0]       n_phi_reg;
    logic [W-1:0]       eslot_reg;
    logic [W-1:0]       pslot_reg;
    logic [2*W-1:0]     total_prod_reg;
    logic [2*W-1:0]     slot_prod_reg;
    logic [ID_W-1:0]    id_reg;
    crm_pkg::status_t   status_reg;
    logic [15:0]        rd_data_reg;
    logic [15:0]        fill_reg [MAX_REGIONS];

    crm_pkg::status_t   out_status_reg;
    logic [9:0]         out_region_reg;
    logic [15:0]        out_hash_reg;
    logic [15:0]        out_pos_reg;
    logic [15:0]        out_total_reg;

    // config-derived divisions
    logic [7:0]               es;
    logic [8:0]               ps;
    logic signed [10:0]       eta_span;
    logic signed [10:0]       phi_span;
    logic [W-1:0]             eta_ceil;
    logic [W-1:0]             phi_ceil;

    logic                      div_start;
    logic                      div_done;
    logic [W-1:0]              eta_dvd;
    logic [W-1:0]              phi_dvd;
    logic                      eta_busy;
    logic                      phi_busy;
    logic [W-1:0]              eta_q;
    logic [W-1:0]              phi_q;

    logic [ID_W-1:0]   id_sum;
    logic              over_cap;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic              pos_ok;

    assign es = (cfg.eta_step == 8'd0) ? 8'd1 : cfg.eta_step;
    assign ps = (cfg.phi_step == 9'd0) ? 9'd1 : cfg.phi_step;

    assign eta_span = 11'(crm_pkg::shift_eta(cfg.eta_last))
                    - 11'(crm_pkg::shift_eta(cfg.eta_first));
    assign phi_span = $signed({2'b0, cfg.phi_last}) - $signed({2'b0, cfg.phi_first});

    // ceiling count, empty window counts zero
    assign eta_ceil = (eta_span > 0) ? W'(eta_span + $signed({3'b0, es}) - 11'sd1) : '0;
    assign phi_ceil = (phi_span > 0) ? W'(phi_span + $signed({2'b0, ps}) - 11'sd1) : '0;

    assign div_done = !eta_busy && !phi_busy;
    assign eta_dvd  = (state_reg == crm_pkg::BK_IDLE) ? eta_ceil : W'(item_reg.eta_off);
    assign phi_dvd  = (state_reg == crm_pkg::BK_IDLE) ? phi_ceil : W'(item_reg.phi_off);

    crm_div u_eta_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (eta_dvd),
        .divisor  ({1'b0, es}),
        .busy     (eta_busy),
        .quotient (eta_q)
    );

    crm_div u_phi_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (phi_dvd),
        .divisor  (ps),
        .busy     (phi_busy),
        .quotient (phi_q)
    );

    assign id_sum   = ID_W'(pslot_reg) + ID_W'(slot_prod_reg);
    assign over_cap = (id_sum >= ID_W'(MAX_REGIONS));
    assign out_free = !out_valid_reg || pop;
    assign pos_ok   = (status_reg == crm_pkg::ST_OK);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            crm_pkg::BK_CLEAR:
            begin
                if (clr_addr_reg == ADDR_W'(MAX_REGIONS - 1))
                    state_next = crm_pkg::BK_IDLE;
            end
            crm_pkg::BK_IDLE:
            begin
                if (!item_empty)
                    state_next = crm_pkg::BK_WAIT_CNT;
            end
            crm_pkg::BK_WAIT_CNT:
            begin
                if (div_done)
                    state_next = crm_pkg::BK_WAIT_SLOT;
            end
            crm_pkg::BK_WAIT_SLOT:
            begin
                if (div_done)
                    state_next = crm_pkg::BK_MUL;
            end
            crm_pkg::BK_MUL:
                state_next = crm_pkg::BK_ADDR;
            crm_pkg::BK_ADDR:
                state_next = crm_pkg::BK_WRITE;
            crm_pkg::BK_WRITE:
            begin
                if (out_free)
                    state_next = crm_pkg::BK_IDLE;
            end
            default:
                state_next = crm_pkg::BK_CLEAR;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        item_pop  = 1'b0;
        div_start = 1'b0;
        clearing  = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = id_reg[ADDR_W-1:0];
        mem_wdata = (rd_data_reg == 16'hFFFF) ? rd_data_reg : rd_data_reg + 16'd1;
        out_load  = 1'b0;
        unique case (state_reg)
            crm_pkg::BK_CLEAR:
            begin
                clearing  = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            crm_pkg::BK_IDLE:
            begin
                item_pop  = !item_empty;
                div_start = !item_empty;
            end
            crm_pkg::BK_WAIT_CNT:
                div_start = div_done;
            crm_pkg::BK_WAIT_SLOT:
                ;
            crm_pkg::BK_MUL:
                ;
            crm_pkg::BK_ADDR:
                mem_re = 1'b1;
            crm_pkg::BK_WRITE:
            begin
                out_load = out_free;
                mem_we   = out_free && pos_ok;
            end
            default:
                clearing = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crm_pkg::BK_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == crm_pkg::BK_CLEAR)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (item_pop)
            item_reg <= item;
        if (state_reg == crm_pkg::BK_WAIT_CNT && div_done)
        begin
            n_eta_reg <= eta_q;
            n_phi_reg <= phi_q;
        end
        if (state_reg == crm_pkg::BK_WAIT_SLOT && div_done)
        begin
            eslot_reg <= eta_q;
            pslot_reg <= phi_q;
        end
        if (state_reg == crm_pkg::BK_MUL)
        begin
            total_prod_reg <= n_eta_reg * n_phi_reg;
            slot_prod_reg  <= n_phi_reg * eslot_reg;
        end
        if (state_reg == crm_pkg::BK_ADDR)
        begin
            id_reg <= id_sum;
            if (item_reg.status != crm_pkg::ST_OK)
                status_reg <= item_reg.status;
            else if (over_cap)
                status_reg <= crm_pkg::ST_OVER_CAP;
            else
                status_reg <= crm_pkg::ST_OK;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_region_reg <= pos_ok ? id_reg[9:0] : 10'd0;
            out_hash_reg   <= item_reg.hash;
            out_pos_reg    <= pos_ok ? rd_data_reg : 16'd0;
            out_total_reg  <= (total_prod_reg[2*W-1:16] != '0) ? 16'hFFFF
                                                               : total_prod_reg[15:0];
        end
    end

    // fill counter store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            fill_reg[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            rd_data_reg <= fill_reg[id_sum[ADDR_W-1:0]];
    end

    assign empty              = !out_valid_reg;
    assign status             = out_status_reg;
    assign region_id          = out_region_reg;
    assign crystal_hash       = out_hash_reg;
    assign position_in_region = out_pos_reg;
    assign region_total       = out_total_reg;

endmodule

`default_nettype wire

>>> hw/rtl/crystal_region_mapper.sv
// top level: config registers, front classifier, request queue and back end
// with the queue empty, an accepted request passes the queue and the back end
//   states BK_IDLE, BK_WAIT_CNT, BK_WAIT_SLOT, BK_MUL, BK_ADDR, BK_WRITE before empty
//   goes low; the back end sequencer takes one request at a time: two rounds of the
//   paired dividers (2 quotient bits per cycle) and the fill counter read-modify-write
// reset: after rst_n the counter memory is cleared one entry a cycle, with full held
//   high; config writes work throughout
`default_nettype none

module crystal_region_mapper #(
    parameter int MAX_REGIONS = crm_pkg::MAX_REGIONS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // config port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [crm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    // request side
    input  wire logic                        push,
    output logic                             full,
    input  wire logic signed [7:0]           eta_index,
    input  wire logic [8:0]                  phi_index,
    // result side
    output logic                             empty,
    input  wire logic                        pop,
    output logic [2:0]                       status,
    output logic [9:0]                       region_id,
    output logic [15:0]                      crystal_hash,
    output logic [15:0]                      position_in_region,
    output logic [15:0]                      region_total
);

    crm_pkg::crm_cfg_t  cfg_reg;
    crm_pkg::crm_item_t front_item;
    crm_pkg::crm_item_t queue_item;

    logic       cfg_wr;
    logic [2:0] cfg_idx;
    logic       wr_en;
    logic       fifo_full;
    logic       fifo_empty;
    logic       item_pop;
    logic       clearing;
    logic       stall;

    // pready held high, no wait states
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eta_first <= crm_pkg::ETA_FIRST_RST;
            cfg_reg.eta_last  <= crm_pkg::ETA_LAST_RST;
            cfg_reg.eta_step  <= crm_pkg::ETA_STEP_RST;
            cfg_reg.phi_first <= crm_pkg::PHI_FIRST_RST;
            cfg_reg.phi_last  <= crm_pkg::PHI_LAST_RST;
            cfg_reg.phi_step  <= crm_pkg::PHI_STEP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                crm_pkg::REG_ETA_FIRST: cfg_reg.eta_first <= pwdata[7:0];
                crm_pkg::REG_ETA_LAST:  cfg_reg.eta_last  <= pwdata[7:0];
                crm_pkg::REG_ETA_STEP:  cfg_reg.eta_step  <= pwdata[7:0];
                crm_pkg::REG_PHI_FIRST: cfg_reg.phi_first <= pwdata[8:0];
                crm_pkg::REG_PHI_LAST:  cfg_reg.phi_last  <= pwdata[8:0];
                crm_pkg::REG_PHI_STEP:  cfg_reg.phi_step  <= pwdata[8:0];
                default:                ;   // unmapped address, write dropped
            endcase
        end
    end

    // read-back
    always_comb
    begin
        unique case (cfg_idx)
            crm_pkg::REG_ETA_FIRST: prdata = {24'd0, cfg_reg.eta_first};
            crm_pkg::REG_ETA_LAST:  prdata = {24'd0, cfg_reg.eta_last};
            crm_pkg::REG_ETA_STEP:  prdata = {24'd0, cfg_reg.eta_step};
            crm_pkg::REG_PHI_FIRST: prdata = {23'd0, cfg_reg.phi_first};
            crm_pkg::REG_PHI_LAST:  prdata = {23'd0, cfg_reg.phi_last};
            crm_pkg::REG_PHI_STEP:  prdata = {23'd0, cfg_reg.phi_step};
            default:                prdata = 32'd0;
        endcase
    end

    // no requests taken while the counter store is being cleared
    assign stall = fifo_full || clearing;
    assign full  = stall;

    crm_front u_front (
        .push      (push),
        .stall     (stall),
        .eta_index (eta_index),
        .phi_index (phi_index),
        .cfg       (cfg_reg),
        .wr_en     (wr_en),
        .item      (front_item)
    );

    // lets the front keep taking requests while the back end iterates
    crm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_data    (front_item),
        .rd_en      (item_pop),
        .rd_data    (queue_item),
        .fifo_full  (fifo_full),
        .fifo_empty (fifo_empty)
    );

    // back end owns the counter store and the result register
    crm_back #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg_reg),
        .item               (queue_item),
        .item_empty         (fifo_empty),
        .item_pop           (item_pop),
        .clearing           (clearing),
        .pop                (pop),
        .empty              (empty),
        .status             (status),
        .region_id          (region_id),
        .crystal_hash       (crystal_hash),
        .position_in_region (position_in_region),
        .region_total       (region_total)
    );

endmodule

`default_nettype wire

>>> hw/rtl/crm_checker.sv
// port-level checks of the crystal region mapper, bound to the top level
`default_nettype none

module crm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        pop,
    input wire logic        empty,
    input wire logic [2:0]  status,
    input wire logic [9:0]  region_id,
    input wire logic [15:0] crystal_hash,
    input wire logic [15:0] position_in_region,
    input wire logic [15:0] region_total
);

    // a waiting result that is not taken stays put
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(region_id)
            && $stable(crystal_hash) && $stable(position_in_region)
            && $stable(region_total)))
        else $error("result changed while waiting");

    // rejected crystals carry no region and no position
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != crm_pkg::ST_OK) |-> (region_id == 10'd0
            && position_in_region == 16'd0))
        else $error("rejected result with region fields set");

    // eta zero never has a hash
    a_eta_zero_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == crm_pkg::ST_ETA_ZERO) |-> (crystal_hash == 16'd0))
        else $error("hash given for eta zero");

    // an accepted crystal implies a non-empty grid
    a_ok_total: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == crm_pkg::ST_OK) |-> (region_total != 16'd0))
        else $error("ok result with zero region total");

    // once reset has been seen at an edge, nothing is offered and nothing is taken
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> (empty && full))
        else $error("handshake active during reset");

endmodule

bind crystal_region_mapper crm_checker u_crm_checker (.*);

`default_nettype wire
